FILE: hdl/ims_pkg.sv
// Shared types and constants of the Ising Metropolis site-update block.
package ims_pkg;

  localparam int COORD_W   = 6;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DE_W      = 5;
  localparam int MAG_W     = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_4 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_8 = 1'b1;

  localparam logic [DATA_W-1:0] THRESH_4_RST = 32'd581260615;
  localparam logic [DATA_W-1:0] THRESH_8_RST = 32'd78665075;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_RD_UP,
    ST_RD_DN,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    RD_CENTER,
    RD_UP,
    RD_DOWN
  } rd_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    reduce_step;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch_ctr;
    logic    latch_up;
    logic    eval;
    logic    commit;
    logic    clr_step;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic reduced;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/ims_if.sv
// Request and result channel interfaces of the Ising site-update block.
interface ims_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [ims_pkg::COORD_W-1:0]       row;
  logic [ims_pkg::COORD_W-1:0]       col;
  logic                              spin_value;
  logic                              sweep_color;
  logic [ims_pkg::DATA_W-1:0]        rand_fraction;

  modport source (
    output valid, req_type, row, col, spin_value, sweep_color, rand_fraction,
    input  ready
  );
  modport sink (
    input  valid, req_type, row, col, spin_value, sweep_color, rand_fraction,
    output ready
  );
endinterface

interface ims_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              spin_after;
  logic                              flipped;
  logic                              updated;
  logic signed [ims_pkg::DE_W-1:0]   energy_change;
  logic signed [ims_pkg::MAG_W-1:0]  magnetization_sum;

  modport source (
    output valid, spin_after, flipped, updated, energy_change, magnetization_sum,
    input  ready
  );
  modport sink (
    input  valid, spin_after, flipped, updated, energy_change, magnetization_sum,
    output ready
  );
endinterface

FILE: hdl/ising_metropolis_site_update.sv
// Ising lattice Metropolis site update, top level.
// Holds a SIDE x SIDE periodic spin lattice (bit 0 = +1, bit 1 = -1) as SIDE rows of SIDE
// bits in one single-port row memory, plus the exact magnetization sum. A load request
// writes one spin; an update request on a site of the given checkerboard color reads
// the center, upper and lower rows in turn, forms dE from the four wrapped neighbors
// and flips when dE <= 0 or rand_fraction is below the threshold for dE of 4 or 8.
// A request passes through range reduction of its coordinates, the center, upper and
// lower row reads, the decision, and the write-back through the memory port together
// with the load of the result register, held while that register holds an untaken
// result. At SIDE below 64 a coordinate at or beyond SIDE is first reduced by SIDE.
// One request is worked at a time; the next one is taken while a result waits.
// After reset the block clears the lattice one row a cycle through all SIDE rows and takes
// no request until done; configuration writes are taken at any time.
module ising_metropolis_site_update #(
  parameter int SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ims_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ims_pkg::DATA_W-1:0]    cfg_wdata,
  ims_req_if.sink                       req,
  ims_rsp_if.source                     rsp
);

  ims_pkg::cmd_t    cmd;
  ims_pkg::status_t st;

  ims_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  ims_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .st        (st)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> st.out_free)
    else $error("result committed while result register busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req.ready)
    else $error("request taken while another is in flight");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("committed result not presented");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.reduce_step, cmd.eval, cmd.commit, cmd.clr_step}))
    else $error("conflicting datapath commands");

endmodule

FILE: hdl/ims_ctrl.sv
// Sequencing state machine of the Ising site-update block.
module ims_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  ims_pkg::status_t st,
  output ims_pkg::cmd_t    cmd
);

  ims_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ims_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = ims_pkg::RD_CENTER;
    case (state)
      ims_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = ims_pkg::ST_IDLE;
      end
      ims_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ims_pkg::ST_REDUCE;
        end
      end
      ims_pkg::ST_REDUCE: begin
        // coordinates in range: start the center row read right away
        if (st.reduced) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ims_pkg::RD_CENTER;
          state_next = ims_pkg::ST_RD_UP;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      ims_pkg::ST_RD_UP: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = ims_pkg::RD_UP;
        cmd.latch_ctr = 1'b1;
        state_next    = ims_pkg::ST_RD_DN;
      end
      ims_pkg::ST_RD_DN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = ims_pkg::RD_DOWN;
        cmd.latch_up = 1'b1;
        state_next   = ims_pkg::ST_EVAL;
      end
      ims_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ims_pkg::ST_WRITE;
      end
      ims_pkg::ST_WRITE: begin
        // hold until the result register can take the transfer
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = ims_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ims_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ims_dp.sv
// Datapath of the Ising site-update block: lattice row memory, flip decision, sum.
module ims_dp #(
  parameter int SIDE = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ims_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ims_pkg::DATA_W-1:0]      cfg_wdata,
  ims_req_if.sink                         req,
  ims_rsp_if.source                       rsp,
  input  ims_pkg::cmd_t                   cmd,
  output ims_pkg::status_t                st
);

  localparam int RW          = $clog2(SIDE);
  localparam int CW          = ims_pkg::COORD_W;
  localparam int CELLS       = SIDE * SIDE;
  localparam int TOT_MIN_W   = $clog2(CELLS + 1) + 1;
  localparam int TOT_W       = (TOT_MIN_W > ims_pkg::MAG_W) ? TOT_MIN_W : ims_pkg::MAG_W;
  localparam int SIDE_CLIP_I = (SIDE > (1 << CW)) ? (1 << CW) : SIDE;
  localparam logic [CW:0]    SIDE_CLIP = (CW + 1)'(SIDE_CLIP_I);
  localparam logic [RW-1:0]  LAST_IDX  = RW'(SIDE - 1);

  // configuration
  logic [ims_pkg::DATA_W-1:0] thresh_4, thresh_8;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_4 <= ims_pkg::THRESH_4_RST;
      thresh_8 <= ims_pkg::THRESH_8_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ims_pkg::CFG_THRESH_4: thresh_4 <= cfg_wdata;
        ims_pkg::CFG_THRESH_8: thresh_8 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured request
  logic                       req_type_q;
  logic [CW-1:0]              row_q, col_q;
  logic                       spin_q, color_q;
  logic [ims_pkg::DATA_W-1:0] rand_q;
  logic                       row_ge, col_ge;

  assign row_ge = {1'b0, row_q} >= SIDE_CLIP;
  assign col_ge = {1'b0, col_q} >= SIDE_CLIP;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q <= req.req_type;
      row_q      <= req.row;
      col_q      <= req.col;
      spin_q     <= req.spin_value;
      color_q    <= req.sweep_color;
      rand_q     <= req.rand_fraction;
    end else if (cmd.reduce_step) begin
      // one modulo step per cycle; only taken when SIDE is below the coordinate range
      if (row_ge) row_q <= row_q - SIDE_CLIP[CW-1:0];
      if (col_ge) col_q <= col_q - SIDE_CLIP[CW-1:0];
    end
  end

  logic [RW-1:0] rrow, rcol, up_row, dn_row, lf_col, rt_col;

  assign rrow   = RW'(row_q);
  assign rcol   = RW'(col_q);
  assign up_row = (rrow == '0) ? LAST_IDX : rrow - RW'(1);
  assign dn_row = (rrow == LAST_IDX) ? '0 : rrow + RW'(1);
  assign lf_col = (rcol == '0) ? LAST_IDX : rcol - RW'(1);
  assign rt_col = (rcol == LAST_IDX) ? '0 : rcol + RW'(1);

  // lattice: one row of spins per word
  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] mem_q;
  logic [RW-1:0]   rd_addr;
  logic [RW-1:0]   clr_cnt;
  logic            mem_we;
  logic [RW-1:0]   wr_addr;
  logic [SIDE-1:0] wr_data;
  logic [SIDE-1:0] new_row;

  always_comb begin
    case (cmd.rd_sel)
      ims_pkg::RD_CENTER: rd_addr = rrow;
      ims_pkg::RD_UP:     rd_addr = up_row;
      ims_pkg::RD_DOWN:   rd_addr = dn_row;
      default:            rd_addr = rrow;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + RW'(1);
    end
  end

  // neighborhood
  logic [SIDE-1:0] center_row;
  logic            up_bit;

  always_ff @(posedge clk) begin
    if (cmd.latch_ctr) center_row <= mem_q;
    if (cmd.latch_up)  up_bit     <= mem_q[rcol];
  end

  logic                   ctr_bit, dn_bit, lf_bit, rt_bit;
  logic [2:0]             same;
  logic [ims_pkg::DE_W-1:0] de_raw;
  logic                   site_match;
  logic                   accept;

  assign ctr_bit = center_row[rcol];
  assign dn_bit  = mem_q[rcol];
  assign lf_bit  = center_row[lf_col];
  assign rt_bit  = center_row[rt_col];

  assign same = {2'b00, up_bit == ctr_bit} + {2'b00, dn_bit == ctr_bit}
              + {2'b00, lf_bit == ctr_bit} + {2'b00, rt_bit == ctr_bit};
  // dE = 4 * same - 8
  assign de_raw = ims_pkg::DE_W'({same, 2'b00}) - ims_pkg::DE_W'(8);
  assign site_match = (req_type_q == ims_pkg::REQ_UPDATE) && ((rrow[0] ^ rcol[0]) == color_q);

  // three matching neighbors give dE = 4, all four give dE = 8
  always_comb begin
    case (same)
      3'd3:    accept = rand_q < thresh_4;
      3'd4:    accept = rand_q < thresh_8;
      default: accept = 1'b1;
    endcase
  end

  logic                     flip_q, upd_q, new_spin_q;
  logic [ims_pkg::DE_W-1:0] de_q;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      upd_q      <= site_match;
      flip_q     <= site_match && accept;
      de_q       <= site_match ? de_raw : '0;
      if (req_type_q == ims_pkg::REQ_LOAD) begin
        new_spin_q <= spin_q;
      end else begin
        new_spin_q <= ctr_bit ^ (site_match && accept);
      end
    end
  end

  always_comb begin
    new_row       = center_row;
    new_row[rcol] = new_spin_q;
  end

  assign mem_we  = cmd.clr_step || cmd.commit;
  assign wr_addr = cmd.clr_step ? clr_cnt : rrow;
  assign wr_data = cmd.clr_step ? '0 : new_row;

  // magnetization
  logic signed [TOT_W-1:0] total, total_next;

  always_comb begin
    total_next = total;
    if (new_spin_q != ctr_bit) begin
      total_next = new_spin_q ? total - TOT_W'(2) : total + TOT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= TOT_W'(CELLS);
    end else if (cmd.commit) begin
      total <= total_next;
    end
  end

  // result register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.spin_after        <= new_spin_q;
      rsp.flipped           <= flip_q;
      rsp.updated           <= upd_q;
      rsp.energy_change     <= de_q;
      rsp.magnetization_sum <= total_next[ims_pkg::MAG_W-1:0];
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = cmd.in_ready;

  assign st.in_valid = req.valid;
  assign st.reduced  = !row_ge && !col_ge;
  assign st.clr_last = (clr_cnt == LAST_IDX);
  assign st.out_free = !out_valid || rsp.ready;

endmodule

FILE: tb/sv/tb_ising_metropolis_site_update.sv
// Self-checking testbench for the Ising lattice Metropolis site-update block.
`timescale 1ns / 100ps

module tb_ising_metropolis_site_update;

  localparam int SIDE        = 64;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 22;

  typedef struct packed {
    logic                            req_type;
    logic [ims_pkg::COORD_W-1:0]     row;
    logic [ims_pkg::COORD_W-1:0]     col;
    logic                            spin_value;
    logic                            sweep_color;
    logic [ims_pkg::DATA_W-1:0]      rand_fraction;
  } site_req_t;

  typedef struct packed {
    logic                             spin_after;
    logic                             flipped;
    logic                             updated;
    logic signed [ims_pkg::DE_W-1:0]  energy_change;
    logic signed [ims_pkg::MAG_W-1:0] magnetization_sum;
  } site_rsp_t;

  // Mirror of the lattice and sum; predicts each site result in transfer order.
  class lattice_scoreboard;
    bit                       spins [SIDE][SIDE];
    int                       spin_total;
    bit [ims_pkg::DATA_W-1:0] thresh4;
    bit [ims_pkg::DATA_W-1:0] thresh8;
    site_rsp_t                due_results [$];
    int                       errors;
    int                       results_seen;
    int                       loads;
    int                       evaluated;
    int                       flips;
    int                       skips;
    int                       de_hits [5];

    function new();
      foreach (spins[r, c]) spins[r][c] = 1'b0;
      spin_total = SIDE * SIDE;
      thresh4    = ims_pkg::THRESH_4_RST;
      thresh8    = ims_pkg::THRESH_8_RST;
    endfunction

    function void set_threshold(logic [ims_pkg::CFG_IDX_W-1:0] idx,
                                logic [ims_pkg::DATA_W-1:0] val);
      if (idx == ims_pkg::CFG_THRESH_4) thresh4 = val;
      else if (idx == ims_pkg::CFG_THRESH_8) thresh8 = val;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void predict_site(site_req_t it);
      site_rsp_t res;
      int        r, c, up, dn, lf, rt, same, de;
      bit        ctr, take;
      r   = it.row % SIDE;
      c   = it.col % SIDE;
      ctr = spins[r][c];
      res = '0;
      de  = 0;
      if (it.req_type == ims_pkg::REQ_LOAD) begin
        loads++;
        if (it.spin_value != ctr) begin
          spin_total += it.spin_value ? -2 : 2;
          spins[r][c] = it.spin_value;
        end
      end else if (((r + c) & 1) == it.sweep_color) begin
        up   = (r + SIDE - 1) % SIDE;
        dn   = (r + 1) % SIDE;
        lf   = (c + SIDE - 1) % SIDE;
        rt   = (c + 1) % SIDE;
        same = int'(spins[up][c] == ctr) + int'(spins[dn][c] == ctr) +
               int'(spins[r][lf] == ctr) + int'(spins[r][rt] == ctr);
        de   = 4 * same - 8;
        evaluated++;
        de_hits[same]++;
        res.updated = 1'b1;
        if (de <= 0) take = 1'b1;
        else if (de == 4) take = it.rand_fraction < thresh4;
        else take = it.rand_fraction < thresh8;
        if (take) begin
          spins[r][c] = !ctr;
          spin_total += ctr ? 2 : -2;
          res.flipped = 1'b1;
          flips++;
        end
      end else begin
        skips++;
      end
      res.spin_after        = spins[r][c];
      res.energy_change     = ims_pkg::DE_W'(de);
      res.magnetization_sum = ims_pkg::MAG_W'(spin_total);
      due_results.push_back(res);
    endfunction

    function void check_site_result(site_rsp_t got);
      site_rsp_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: spin %0b flip %0b upd %0b dE %0d sum %0d",
                   $time, got.spin_after, got.flipped, got.updated,
                   got.energy_change, got.magnetization_sum);
        return;
      end
      want = due_results.pop_front();
      if (got.spin_after !== want.spin_after || got.flipped !== want.flipped ||
          got.updated !== want.updated || got.energy_change !== want.energy_change ||
          got.magnetization_sum !== want.magnetization_sum) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] result %0d: exp spin %0b flip %0b upd %0b dE %0d sum %0d",
                    " / got %0b %0b %0b %0d %0d"},
                   $time, results_seen, want.spin_after, want.flipped, want.updated,
                   want.energy_change, want.magnetization_sum, got.spin_after,
                   got.flipped, got.updated, got.energy_change, got.magnetization_sum);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [ims_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ims_pkg::DATA_W-1:0]    cfg_wdata;

  ims_req_if req_ch ();
  ims_rsp_if rsp_ch ();

  ising_metropolis_site_update #(.SIDE(SIDE)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  lattice_scoreboard sb = new();

  bit req_calm;
  bit rsp_calm;
  bit rsp_hold_go;
  int cycles;
  int settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("ising_metropolis_site_update verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, none in calm phases, plus one long hold when asked.
  initial begin
    int hold_left;
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_hold_go) begin
        rsp_hold_go = 1'b0;
        hold_left   = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_calm) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    site_rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.spin_after        = rsp_ch.spin_after;
      got.flipped           = rsp_ch.flipped;
      got.updated           = rsp_ch.updated;
      got.energy_change     = rsp_ch.energy_change;
      got.magnetization_sum = rsp_ch.magnetization_sum;
      sb.check_site_result(got);
    end
  end

  function automatic site_req_t mk_req(logic kind, int r, int c, logic spin, logic color,
                                       logic [ims_pkg::DATA_W-1:0] frac);
    site_req_t it;
    it.req_type      = kind;
    it.row           = ims_pkg::COORD_W'(r);
    it.col           = ims_pkg::COORD_W'(c);
    it.spin_value    = spin;
    it.sweep_color   = color;
    it.rand_fraction = frac;
    return it;
  endfunction

  // Half the time small windows (one across the wrap corner) so neighborhoods get mixed.
  function automatic site_req_t random_site_req();
    site_req_t                  it;
    int                         base, pick;
    logic [ims_pkg::DATA_W-1:0] thr;
    it.req_type = ($urandom_range(99) < 35) ? ims_pkg::REQ_LOAD : ims_pkg::REQ_UPDATE;
    if ($urandom_range(1)) begin
      base   = $urandom_range(1) ? 62 : 30;
      it.row = ims_pkg::COORD_W'((base + $urandom_range(4)) % SIDE);
      it.col = ims_pkg::COORD_W'((base + $urandom_range(4)) % SIDE);
    end else begin
      it.row = ims_pkg::COORD_W'($urandom_range(SIDE - 1));
      it.col = ims_pkg::COORD_W'($urandom_range(SIDE - 1));
    end
    it.spin_value = $urandom_range(1);
    if (it.req_type == ims_pkg::REQ_UPDATE && $urandom_range(99) < 85)
      it.sweep_color = it.row[0] ^ it.col[0];
    else
      it.sweep_color = $urandom_range(1);
    pick = $urandom_range(19);
    if (pick < 10) begin
      it.rand_fraction = $urandom();
    end else if (pick < 16) begin
      thr = pick[0] ? sb.thresh4 : sb.thresh8;
      it.rand_fraction = thr + ims_pkg::DATA_W'($urandom_range(2)) - 32'd1;
    end else if (pick < 18) begin
      it.rand_fraction = '0;
    end else begin
      it.rand_fraction = '1;
    end
    return it;
  endfunction

  task automatic send_req(site_req_t it);
    while (!req_calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= it.req_type;
    req_ch.row           <= it.row;
    req_ch.col           <= it.col;
    req_ch.spin_value    <= it.spin_value;
    req_ch.sweep_color   <= it.sweep_color;
    req_ch.rand_fraction <= it.rand_fraction;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.predict_site(it);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [ims_pkg::DATA_W-1:0] t4,
                                logic [ims_pkg::DATA_W-1:0] t8);
    cfg_we    <= 1'b1;
    cfg_index <= ims_pkg::CFG_THRESH_4;
    cfg_wdata <= t4;
    @(posedge clk);
    cfg_index <= ims_pkg::CFG_THRESH_8;
    cfg_wdata <= t8;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_threshold(ims_pkg::CFG_THRESH_4, t4);
    sb.set_threshold(ims_pkg::CFG_THRESH_8, t8);
    settings_used++;
  endtask

  // Wrap corners, both load outcomes, skips, dE of -8, 0, +4 and +8 and both sides of each threshold.
  task automatic run_directed();
    send_req(mk_req(ims_pkg::REQ_LOAD,    0,  0, 1'b1, 1'b0, 32'h0));
    send_req(mk_req(ims_pkg::REQ_LOAD,    0,  0, 1'b1, 1'b1, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE,  0,  0, 1'b0, 1'b0, 32'h1234_5678));
    send_req(mk_req(ims_pkg::REQ_UPDATE,  0,  0, 1'b1, 1'b1, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 63, 63, 1'b0, 1'b0, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE,  0,  2, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(ims_pkg::REQ_LOAD,   63,  0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(ims_pkg::REQ_LOAD,    0, 63, 1'b1, 1'b0, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 63, 63, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(ims_pkg::REQ_UPDATE,  1, 63, 1'b0, 1'b0,
                    ims_pkg::THRESH_4_RST - 32'd1));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 63,  1, 1'b0, 1'b0, ims_pkg::THRESH_4_RST));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 10, 10, 1'b0, 1'b0,
                    ims_pkg::THRESH_8_RST - 32'd1));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 20, 20, 1'b0, 1'b0, ims_pkg::THRESH_8_RST));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 21, 20, 1'b1, 1'b1, 32'hAAAA_AAAA));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 20, 21, 1'b0, 1'b0, 32'h5555_5555));
    send_req(mk_req(ims_pkg::REQ_LOAD,   63, 63, 1'b0, 1'b1, 32'h0));
    send_req(mk_req(ims_pkg::REQ_LOAD,    0,  0, 1'b0, 1'b0, 32'h0));
    send_req(mk_req(ims_pkg::REQ_LOAD,   33, 44, 1'b1, 1'b1, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 33, 44, 1'b0, 1'b0, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 33, 44, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_req(mk_req(ims_pkg::REQ_LOAD,   42, 21, 1'b0, 1'b1, 32'h0));
    send_req(mk_req(ims_pkg::REQ_UPDATE, 42, 21, 1'b1, 1'b1, 32'h8000_0000));
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = ims_pkg::CFG_THRESH_4;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = ims_pkg::REQ_LOAD;
    req_ch.row           = '0;
    req_ch.col           = '0;
    req_ch.spin_value    = 1'b0;
    req_ch.sweep_color   = 1'b0;
    req_ch.rand_fraction = '0;
    clk                  = 1'b0;
    settings_used        = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      // hold phase 0 at the reset thresholds; later phases set the extremes, then random and mixed values
      case (ph)
        1: set_thresholds(32'h0000_0000, 32'h0000_0000);
        2: set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_thresholds($urandom(), $urandom());
        4: set_thresholds(32'h8000_0000, 32'h0000_0001);
        default: ;
      endcase
      req_calm = (ph == 2);
      rsp_calm = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 100) rsp_hold_go = 1'b1;
        send_req(random_site_req());
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d evaluated updates (%0d flips), %0d skipped sites",
             sb.loads, sb.evaluated, sb.flips, sb.skips);
    $display("%0d threshold settings; dE counts -8:%0d -4:%0d 0:%0d +4:%0d +8:%0d",
             settings_used, sb.de_hits[0], sb.de_hits[1], sb.de_hits[2],
             sb.de_hits[3], sb.de_hits[4]);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ising_metropolis_site_update verification clean");
    end else begin
      $display("%0d results never arrived", sb.pending());
      $display("ising_metropolis_site_update verification failed");
    end
    $finish;
  end

endmodule
